>>> sv/positional_insert_delete_list_core_assert.svh
// Assertion macros shared by the list core RTL.
// Depends on nothing; files that assert include it by name.
`ifndef POSITIONAL_INSERT_DELETE_LIST_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in list core");

// The consequent must hold in the cycle after the antecedent.
`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in list core");

`endif

>>> sv/pidl_pkg.sv
// Types and constants for the positional insert/delete list core.
// Used by the interfaces, the cell chain and the top level; depends on nothing.
`default_nettype none

package pidl_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int FIELD_W  = 6;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [LEN_W-1:0]         len_t;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_COUNT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    idx_t      pos0;
    idx_t      last_idx;
    data_t     value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/pidl_req_if.sv
// Request channel of the list core: valid/ready handshake with op, value, position.
// Depends on pidl_pkg.
`default_nettype none

interface pidl_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic signed [pidl_pkg::DATA_W-1:0] value;
  logic [pidl_pkg::POS_W-1:0]     position;

  modport source (output valid, op, value, position, input ready);
  modport sink (input valid, op, value, position, output ready);
endinterface

`default_nettype wire

>>> sv/pidl_rsp_if.sv
// Response channel of the list core: valid/ready handshake with the result fields.
// Depends on pidl_pkg.
`default_nettype none

interface pidl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [pidl_pkg::DATA_W-1:0] element;
  logic [pidl_pkg::FIELD_W-1:0]       element_index;
  logic [pidl_pkg::FIELD_W-1:0]       length;
  logic                               last;

  modport source (output valid, status, element, element_index, length, last, input ready);
  modport sink (input valid, status, element, element_index, length, last, output ready);
endinterface

`default_nettype wire

>>> sv/pidl_cell.sv
// One storage cell of the list chain: holds one value and loads from its neighbors.
// Depends on pidl_pkg.
`default_nettype none

module pidl_cell (
  input  wire logic                 clk,
  input  wire pidl_pkg::cell_ctrl_t ctrl,
  input  wire pidl_pkg::idx_t       idx,
  input  wire pidl_pkg::data_t      left,
  input  wire pidl_pkg::data_t      right,
  input  wire pidl_pkg::data_t      first,
  output pidl_pkg::data_t           q
);

  pidl_pkg::data_t q_next;

  always_comb begin
    q_next = q;
    case (ctrl.cmd)
      pidl_pkg::CMD_INSERT: begin
        if (idx == ctrl.pos0) begin
          q_next = ctrl.value;
        end else if (idx > ctrl.pos0) begin
          q_next = left;
        end
      end
      pidl_pkg::CMD_DELETE: begin
        if (idx >= ctrl.pos0) begin
          q_next = right;
        end
      end
      pidl_pkg::CMD_ROTATE: begin
        if (idx == ctrl.last_idx) begin
          q_next = first;
        end else if (idx < ctrl.last_idx) begin
          q_next = right;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

>>> sv/pidl_chain.sv
// List cell row, one control word; each sees its neighbors, zero/self at ends.
// Depends on pidl_pkg and pidl_cell.
`default_nettype none

module pidl_chain (
  input  wire logic                 clk,
  input  wire pidl_pkg::cell_ctrl_t ctrl,
  output pidl_pkg::data_t           head
);

  pidl_pkg::data_t q [pidl_pkg::CAPACITY];

  for (genvar i = 0; i < pidl_pkg::CAPACITY; i++) begin : g_cell
    pidl_pkg::data_t left_in;
    pidl_pkg::data_t right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = q[i-1];
    end

    if (i == pidl_pkg::CAPACITY - 1) begin : g_last
      assign right_in = q[i];
    end else begin : g_mid_r
      assign right_in = q[i+1];
    end

    pidl_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (pidl_pkg::IDX_W'(i)),
      .left  (left_in),
      .right (right_in),
      .first (q[0]),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

`default_nettype wire

>>> sv/positional_insert_delete_list_core.sv
// Top level of the positional insert/delete list core: control, length and result register.
// Depends on pidl_pkg, pidl_req_if, pidl_rsp_if, pidl_chain and the assertion header.
//
// The list is held in a row of cells, so an insert or delete shifts every later
// value at once; insert, delete and count each give one result, and a new request
// is taken whenever the block is idle and the result register is empty or being
// drained. A traverse first enters its streaming state and then streams one result
// per cycle while the result register is free, length values followed by an end
// marker flagged last, by rotating the occupied cells past the head; no request is
// taken until the end marker is loaded. There is no clearing pass after reset:
// only positions below the current length are ever read.
`default_nettype none

module positional_insert_delete_list_core (
  input  wire logic  clk,
  input  wire logic  rst,
  pidl_req_if.sink   req,
  pidl_rsp_if.source rsp
);

  `include "positional_insert_delete_list_core_assert.svh"

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_t;

  state_t                        state;
  pidl_pkg::len_t                len;
  pidl_pkg::len_t                cnt;
  logic                          ov;
  pidl_pkg::status_t             o_status;
  pidl_pkg::data_t               o_element;
  logic [pidl_pkg::FIELD_W-1:0]  o_index;
  logic [pidl_pkg::FIELD_W-1:0]  o_length;
  logic                          o_last;

  pidl_pkg::cell_ctrl_t          ctrl;
  pidl_pkg::data_t               head;
  pidl_pkg::op_t                 op;
  logic                          slot_free;
  logic                          accept;
  logic [pidl_pkg::CMP_W-1:0]    pos_x;
  logic [pidl_pkg::CMP_W-1:0]    len_x;
  logic                          ins_range;
  logic                          ins_ok;
  logic                          del_ok;
  logic                          rot_step;
  pidl_pkg::status_t             status_next;
  pidl_pkg::len_t                len_next;

  assign op        = pidl_pkg::op_t'(req.op);
  assign slot_free = !ov || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;

  assign pos_x     = pidl_pkg::CMP_W'(req.position);
  assign len_x     = pidl_pkg::CMP_W'(len);
  assign ins_range = (pos_x == '0) || (pos_x > len_x + 1'b1);
  assign ins_ok    = !ins_range && (len_x < pidl_pkg::CMP_W'(pidl_pkg::CAPACITY));
  assign del_ok    = (len != '0) && (pos_x != '0) && (pos_x <= len_x);
  assign rot_step  = (state == S_TRAV) && slot_free && (cnt < len);

  always_comb begin
    status_next = pidl_pkg::ST_OK;
    len_next    = len;
    case (op)
      pidl_pkg::OP_INSERT: begin
        if (ins_range) begin
          status_next = pidl_pkg::ST_RANGE;
        end else if (!ins_ok) begin
          status_next = pidl_pkg::ST_FULL;
        end else begin
          len_next = len + 1'b1;
        end
      end
      pidl_pkg::OP_DELETE: begin
        if (len == '0) begin
          status_next = pidl_pkg::ST_EMPTY;
        end else if (!del_ok) begin
          status_next = pidl_pkg::ST_RANGE;
        end else begin
          len_next = len - 1'b1;
        end
      end
      default: status_next = pidl_pkg::ST_OK;
    endcase
  end

  always_comb begin
    ctrl.cmd      = pidl_pkg::CMD_HOLD;
    ctrl.pos0     = pidl_pkg::IDX_W'(req.position - 1'b1);
    ctrl.last_idx = pidl_pkg::IDX_W'(len - 1'b1);
    ctrl.value    = req.value;
    if (accept && (op == pidl_pkg::OP_INSERT) && ins_ok) begin
      ctrl.cmd = pidl_pkg::CMD_INSERT;
    end else if (accept && (op == pidl_pkg::OP_DELETE) && del_ok) begin
      ctrl.cmd = pidl_pkg::CMD_DELETE;
    end else if (rot_step) begin
      ctrl.cmd = pidl_pkg::CMD_ROTATE;
    end
  end

  pidl_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      if (ov && rsp.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == pidl_pkg::OP_TRAVERSE) begin
              state <= S_TRAV;
              cnt   <= '0;
            end else begin
              len       <= len_next;
              ov        <= 1'b1;
              o_status  <= status_next;
              o_element <= '0;
              o_index   <= '0;
              o_length  <= pidl_pkg::FIELD_W'(len_next);
              o_last    <= 1'b1;
            end
          end
        end
        S_TRAV: begin
          if (slot_free) begin
            ov       <= 1'b1;
            o_status <= pidl_pkg::ST_OK;
            o_length <= pidl_pkg::FIELD_W'(len);
            if (cnt < len) begin
              o_element <= head;
              o_index   <= pidl_pkg::FIELD_W'(cnt + 1'b1);
              o_last    <= 1'b0;
              cnt       <= cnt + 1'b1;
            end else begin
              o_element <= '0;
              o_index   <= '0;
              o_last    <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = ov;
  assign rsp.status        = o_status;
  assign rsp.element       = o_element;
  assign rsp.element_index = o_index;
  assign rsp.length        = o_length;
  assign rsp.last          = o_last;

  `PIDL_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, len <= pidl_pkg::LEN_W'(pidl_pkg::CAPACITY))
  `PIDL_ASSERT_NOW(a_trav_cnt, clk, rst, state == S_TRAV, cnt <= len)
  `PIDL_ASSERT_NEXT(a_ins_grow, clk, rst, accept && (op == pidl_pkg::OP_INSERT) && ins_ok, len == $past(len) + 1'b1)
  `PIDL_ASSERT_NEXT(a_del_shrink, clk, rst, accept && (op == pidl_pkg::OP_DELETE) && del_ok, len == $past(len) - 1'b1)

endmodule

`default_nettype wire
